### hdl/plss_pkg.sv
// Shared constants and types for the positional list store with sort.
`timescale 1ns / 1ps

package plss_pkg;

	localparam int DEPTH_DEFAULT = 32;

	localparam int MODE_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 7;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INS_TAIL = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INS_POS  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DEL_HEAD = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DEL_TAIL = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DEL_POS  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SORT     = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SHOW     = 3'd7;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

	localparam int CMD_W = 3;
	localparam logic [CMD_W-1:0] CMD_HOLD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ROTATE = 3'd4;

	// broadcast to every cell each cycle
	typedef struct packed {
		logic [CMD_W-1:0]          op;
		logic                      phase;
		logic [COUNT_W-1:0]        at;
		logic [COUNT_W-1:0]        count;
		logic signed [VALUE_W-1:0] value;
	} cell_cmd_t;

endpackage

### hdl/plss_cell.sv
// One list entry: holds a value and moves it to or from its neighbors.
`timescale 1ns / 1ps

module plss_cell
	import plss_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  cell_cmd_t                 cmd,
	input  logic signed [VALUE_W-1:0] left_data,
	input  logic signed [VALUE_W-1:0] right_data,
	input  logic signed [VALUE_W-1:0] head_data,
	input  logic                      left_gt,
	output logic signed [VALUE_W-1:0] data,
	output logic                      gt
);

	localparam logic [COUNT_W:0] POS_LO = (COUNT_W+1)'(IDX);
	localparam logic [COUNT_W:0] POS_HI = (COUNT_W+1)'(IDX + 1);
	localparam logic             ODD    = 1'(IDX % 2);

	logic signed [VALUE_W-1:0] data_q;
	logic signed [VALUE_W-1:0] data_d;
	logic [COUNT_W:0]          at_x;
	logic [COUNT_W:0]          cnt_x;

	assign at_x  = {1'b0, cmd.at};
	assign cnt_x = {1'b0, cmd.count};
	assign data  = data_q;
	assign gt    = data_q > right_data;

	always_comb begin
		data_d = data_q;
		case (cmd.op)
			CMD_INSERT: begin
				if (POS_LO == at_x)
					data_d = cmd.value;
				else if (POS_LO > at_x && POS_LO <= cnt_x)
					data_d = left_data;
			end
			CMD_DELETE: begin
				if (POS_LO >= at_x && POS_HI < cnt_x)
					data_d = right_data;
			end
			CMD_ROTATE: begin
				if (POS_HI < cnt_x)
					data_d = right_data;
				else if (POS_HI == cnt_x)
					data_d = head_data;
			end
			CMD_SWAP: begin
				// lower cell of a pair keeps the min, upper keeps the max
				if (ODD == cmd.phase && POS_HI < cnt_x && gt)
					data_d = right_data;
				else if (ODD != cmd.phase && POS_LO != '0 && POS_LO < cnt_x && left_gt)
					data_d = left_data;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

### hdl/plss_ctrl.sv
// Sequencer: decodes items, keeps the count, drives the cells and the result register.
`timescale 1ns / 1ps

module plss_ctrl
	import plss_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [MODE_W-1:0]         mode,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [POS_W-1:0]          position,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [STATUS_W-1:0]       status,
	output logic [COUNT_W-1:0]        count,
	output logic signed [VALUE_W-1:0] element,
	output logic                      last_item,
	input  logic signed [VALUE_W-1:0] head_data,
	output cell_cmd_t                 cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SORT = 2'd1;
	localparam logic [1:0] S_SHOW = 2'd2;
	localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);

	logic [1:0]          state_q, state_d;
	logic [COUNT_W-1:0]  count_q, count_d;
	logic [COUNT_W-1:0]  pass_q, pass_d;
	logic [COUNT_W-1:0]  idx_q, idx_d;
	logic                phase_q, phase_d;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic signed [VALUE_W-1:0] out_elem_q;
	logic                out_last_q;

	logic                slot_free;
	logic                accept;
	logic                load;
	logic [STATUS_W-1:0] ld_status;
	logic signed [VALUE_W-1:0] ld_elem;
	logic                ld_last;
	logic                empty;
	logic                full;
	logic                bad_pos;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && slot_free;
	assign accept    = s_tvalid && s_tready;
	assign empty     = count_q == '0;
	assign full      = count_q == FULL_CNT;
	assign bad_pos   = position == '0 || position > count_q;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pass_d    = pass_q;
		idx_d     = idx_q;
		phase_d   = phase_q;
		load      = 1'b0;
		ld_status = ST_OK;
		ld_elem   = '0;
		ld_last   = 1'b1;
		cmd.op    = CMD_HOLD;
		cmd.phase = phase_q;
		cmd.at    = '0;
		cmd.count = count_q;
		cmd.value = value;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					load = 1'b1;
					case (mode)
						MODE_INS_HEAD, MODE_INS_TAIL: begin
							if (full) begin
								ld_status = ST_FULL;
							end else begin
								cmd.op  = CMD_INSERT;
								cmd.at  = (mode == MODE_INS_HEAD) ? '0 : count_q;
								count_d = count_q + 1'b1;
							end
						end
						MODE_INS_POS: begin
							if (bad_pos) begin
								ld_status = ST_BADPOS;
							end else if (full) begin
								ld_status = ST_FULL;
							end else begin
								cmd.op  = CMD_INSERT;
								cmd.at  = position;
								count_d = count_q + 1'b1;
							end
						end
						MODE_DEL_HEAD, MODE_DEL_TAIL: begin
							if (empty) begin
								ld_status = ST_EMPTY;
							end else begin
								cmd.op  = CMD_DELETE;
								cmd.at  = (mode == MODE_DEL_HEAD) ? '0 : count_q - 1'b1;
								count_d = count_q - 1'b1;
							end
						end
						MODE_DEL_POS: begin
							if (empty) begin
								ld_status = ST_EMPTY;
							end else if (bad_pos) begin
								ld_status = ST_BADPOS;
							end else begin
								cmd.op  = CMD_DELETE;
								cmd.at  = position - 1'b1;
								count_d = count_q - 1'b1;
							end
						end
						MODE_SORT: begin
							if (empty) begin
								ld_status = ST_EMPTY;
							end else begin
								load    = 1'b0;
								pass_d  = count_q;
								phase_d = 1'b0;
								state_d = S_SORT;
							end
						end
						default: begin
							if (empty) begin
								ld_status = ST_EMPTY;
							end else begin
								load    = 1'b0;
								idx_d   = '0;
								state_d = S_SHOW;
							end
						end
					endcase
				end
			end
			S_SORT: begin
				// odd-even transposition, one pass per stored entry
				if (pass_q != '0) begin
					cmd.op  = CMD_SWAP;
					pass_d  = pass_q - 1'b1;
					phase_d = ~phase_q;
				end else if (slot_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SHOW: begin
				// emit the head and rotate; after count steps the order is back
				if (slot_free) begin
					load    = 1'b1;
					ld_elem = head_data;
					ld_last = idx_q == count_q - 1'b1;
					cmd.op  = CMD_ROTATE;
					idx_d   = idx_q + 1'b1;
					if (ld_last)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pass_q      <= '0;
			idx_q       <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pass_q  <= pass_d;
			idx_q   <= idx_d;
			phase_q <= phase_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= ld_status;
			out_count_q  <= count_d;
			out_elem_q   <= ld_elem;
			out_last_q   <= ld_last;
		end
	end

	assign m_tvalid  = out_valid_q;
	assign status    = out_status_q;
	assign count     = out_count_q;
	assign element   = out_elem_q;
	assign last_item = out_last_q;

endmodule

### hdl/positional_list_store_with_sort_top.sv
// Top level: positional list store with sort, a sequencer over a chain of entry cells.
//
//  channel   direction  tdata (low bit up)                   tuser        tlast
//  s_*       in         value[31:0], position[38:32], pad     mode[2:0]    -
//  m_*       out        count[6:0], element[38:7], pad        status[1:0]  last_item
//
// Inserts and deletes update every cell together: each cell shifts toward or away from the
// changed slot at once. Sort runs one odd-even pass per stored entry.
// Show emits one result per cycle while m_tready holds, rotating the chain.
// The one-deep result register frees at the edge its result is taken, so a new item
// can enter at that same edge; while a result waits, s_tready stays low.
// arst_n clears the count and control; cell contents are never cleared.
`timescale 1ns / 1ps

module positional_list_store_with_sort_top
	import plss_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // value[31:0], position[38:32]
	input  logic [MODE_W-1:0]     s_tuser,   // mode[2:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // count[6:0], element[38:7]
	output logic [STATUS_W-1:0]   m_tuser,   // status[1:0]
	output logic                  m_tlast
);

	cell_cmd_t                 cmd;
	logic signed [VALUE_W-1:0] cell_data [DEPTH];
	logic                      cell_gt   [DEPTH];
	logic [COUNT_W-1:0]        count;
	logic signed [VALUE_W-1:0] element;

	plss_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser),
		.value    (s_tdata[VALUE_W-1:0]),
		.position (s_tdata[VALUE_W+POS_W-1:VALUE_W]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (m_tuser),
		.count    (count),
		.element  (element),
		.last_item(m_tlast),
		.head_data(cell_data[0]),
		.cmd      (cmd)
	);

	assign m_tdata = {{(OUT_DATA_W-COUNT_W-VALUE_W){1'b0}}, element, count};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VALUE_W-1:0] left_w;
		logic signed [VALUE_W-1:0] right_w;
		logic                      left_gt_w;

		if (i == 0) begin : g_first
			assign left_w    = '0;
			assign left_gt_w = 1'b0;
		end else begin : g_mid
			assign left_w    = cell_data[i-1];
			assign left_gt_w = cell_gt[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner
			assign right_w = cell_data[i+1];
		end

		plss_cell #(
			.IDX(i)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.left_data (left_w),
			.right_data(right_w),
			.head_data (cell_data[0]),
			.left_gt   (left_gt_w),
			.data      (cell_data[i]),
			.gt        (cell_gt[i])
		);
	end

endmodule

### bench/positional_list_store_with_sort_top_tb.sv
// Testbench for the positional list store with sort: directed and random list operations.
`timescale 1ns / 1ps

module positional_list_store_with_sort_top_tb;
	import plss_pkg::*;

	localparam int DEPTH       = DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int PHASE_ITEMS = 40;

	typedef enum int {PH_GROW, PH_MIXED, PH_SHRINK} phase_e;

	typedef struct {
		logic [STATUS_W-1:0]       status;
		logic [COUNT_W-1:0]        count;
		logic signed [VALUE_W-1:0] element;
		logic                      last_item;
	} list_result_t;

	// keeps a copy of the list and the results it still owes
	class list_scoreboard;
		logic signed [VALUE_W-1:0] vals[DEPTH];
		int unsigned n;
		list_result_t pending[$];
		int errors;
		int checked;

		function new();
			n = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void owe(logic [STATUS_W-1:0] st, logic signed [VALUE_W-1:0] elem, logic fin);
			list_result_t r;
			r.status = st;
			r.count = n[COUNT_W-1:0];
			r.element = elem;
			r.last_item = fin;
			pending.push_back(r);
		endfunction

		function void place(int unsigned at, logic signed [VALUE_W-1:0] v);
			for (int unsigned i = n; i > at; i--)
				vals[i] = vals[i-1];
			vals[at] = v;
			n++;
		endfunction

		function void remove(int unsigned at);
			for (int unsigned i = at; i + 1 < n; i++)
				vals[i] = vals[i+1];
			n--;
		endfunction

		function void sort_ascending();
			logic signed [VALUE_W-1:0] v;
			int j;
			for (int i = 1; i < int'(n); i++) begin
				v = vals[i];
				j = i;
				while (j > 0 && vals[j-1] > v) begin
					vals[j] = vals[j-1];
					j--;
				end
				vals[j] = v;
			end
		endfunction

		function void note_request(logic [MODE_W-1:0] mode, logic signed [VALUE_W-1:0] value,
				logic [POS_W-1:0] pos);
			logic [STATUS_W-1:0] st;
			st = ST_OK;
			case (mode)
				MODE_INS_HEAD, MODE_INS_TAIL: begin
					if (n >= DEPTH)
						st = ST_FULL;
					else
						place(mode == MODE_INS_HEAD ? 0 : n, value);
				end
				MODE_INS_POS: begin
					// bad position wins over full
					if (pos < 1 || pos > n)
						st = ST_BADPOS;
					else if (n >= DEPTH)
						st = ST_FULL;
					else
						place(pos, value);
				end
				MODE_DEL_HEAD, MODE_DEL_TAIL: begin
					if (n == 0)
						st = ST_EMPTY;
					else
						remove(mode == MODE_DEL_HEAD ? 0 : n - 1);
				end
				MODE_DEL_POS: begin
					if (n == 0)
						st = ST_EMPTY;
					else if (pos < 1 || pos > n)
						st = ST_BADPOS;
					else
						remove(pos - 1);
				end
				MODE_SORT: begin
					if (n == 0)
						st = ST_EMPTY;
					else
						sort_ascending();
				end
				default: begin
					if (n == 0)
						st = ST_EMPTY;
					else begin
						for (int unsigned i = 0; i < n; i++)
							owe(ST_OK, vals[i], i + 1 == n);
						return;
					end
				end
			endcase
			owe(st, '0, 1'b1);
		endfunction

		function void check_result(list_result_t got);
			list_result_t exp_r;
			checked++;
			if (pending.size() == 0) begin
				$error("unexpected result: status %0d count %0d element %0d last %0b",
					got.status, got.count, got.element, got.last_item);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.status !== exp_r.status) begin
				$error("status mismatch: expected %0d, got %0d", exp_r.status, got.status);
				errors++;
			end
			if (got.count !== exp_r.count) begin
				$error("count mismatch: expected %0d, got %0d", exp_r.count, got.count);
				errors++;
			end
			if (got.element !== exp_r.element) begin
				$error("element mismatch: expected %0d, got %0d", exp_r.element, got.element);
				errors++;
			end
			if (got.last_item !== exp_r.last_item) begin
				$error("last_item mismatch: expected %0b, got %0b",
					exp_r.last_item, got.last_item);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [MODE_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]   m_tuser;
	logic                  m_tlast;

	list_scoreboard sb = new();
	bit quiet_tx;
	int cycles;

	positional_list_store_with_sort_top #(
		.DEPTH(DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		list_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tuser;
			got.count = m_tdata[COUNT_W-1:0];
			got.element = m_tdata[COUNT_W +: VALUE_W];
			got.last_item = m_tlast;
			sb.check_result(got);
		end
	end

	// result side: random stalls, with stall-free stretches every so often
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = ((sb.checked / 50) % 3 == 1) ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	task automatic send_request(input logic [MODE_W-1:0] mode,
			input logic signed [VALUE_W-1:0] value, input logic [POS_W-1:0] pos);
		int gap;
		gap = quiet_tx ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, pos, value};
		s_tuser <= mode;
		do @(posedge clk); while (!s_tready);
		sb.note_request(mode, value, pos);
		@(negedge clk);
	endtask

	function automatic logic [POS_W-1:0] pick_position();
		int r;
		int top;
		r = $urandom_range(0, 9);
		top = (sb.n > 0) ? sb.n : 1;
		if (r < 7)
			return POS_W'($urandom_range(1, top));
		else if (r == 7)
			return '0;
		else if (r == 8)
			return POS_W'(sb.n + 1);
		return POS_W'($urandom_range(0, 127));
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value();
		// small values give the sort plenty of duplicates
		if ($urandom_range(0, 3) == 0)
			return VALUE_W'(int'($urandom_range(0, 8)) - 4);
		return $urandom;
	endfunction

	function automatic logic [MODE_W-1:0] pick_mode(phase_e ph);
		int r;
		r = $urandom_range(0, 99);
		if (ph == PH_MIXED)
			return MODE_W'($urandom_range(0, 7));
		if (r < 85) begin
			if (ph == PH_GROW)
				return MODE_W'($urandom_range(MODE_INS_HEAD, MODE_INS_POS));
			return MODE_W'($urandom_range(MODE_DEL_HEAD, MODE_DEL_POS));
		end
		if (r < 92) begin
			if (ph == PH_GROW)
				return MODE_W'($urandom_range(MODE_DEL_HEAD, MODE_DEL_POS));
			return MODE_W'($urandom_range(MODE_INS_HEAD, MODE_INS_POS));
		end
		return (r < 96) ? MODE_SORT : MODE_SHOW;
	endfunction

	initial begin
		phase_e plan[7];
		plan = '{PH_GROW, PH_MIXED, PH_SHRINK, PH_GROW, PH_GROW, PH_SHRINK, PH_MIXED};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_INS_HEAD;
		quiet_tx = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty-list cases
		send_request(MODE_SHOW, 32'sd0, 7'd0);
		send_request(MODE_DEL_HEAD, 32'sd0, 7'd0);
		send_request(MODE_DEL_TAIL, 32'sd0, 7'd0);
		send_request(MODE_DEL_POS, 32'sd0, 7'd1);
		send_request(MODE_SORT, 32'sd0, 7'd0);
		send_request(MODE_INS_POS, 32'sd5, 7'd1);
		// value extremes, insert after the last position acts as tail insert
		send_request(MODE_INS_HEAD, 32'sh7FFFFFFF, 7'd0);
		send_request(MODE_INS_TAIL, 32'sh80000000, 7'd0);
		send_request(MODE_INS_POS, -32'sd1, 7'd2);
		send_request(MODE_INS_POS, 32'sd9, 7'd0);
		send_request(MODE_INS_POS, 32'sd9, 7'd127);
		send_request(MODE_INS_POS, 32'sd0, 7'd1);
		send_request(MODE_SHOW, 32'sd0, 7'd0);
		send_request(MODE_SORT, 32'sd0, 7'd0);
		send_request(MODE_SHOW, 32'sd0, 7'd0);
		send_request(MODE_DEL_POS, 32'sd0, 7'd0);
		send_request(MODE_DEL_POS, 32'sd0, 7'd64);
		send_request(MODE_DEL_POS, 32'sd0, 7'd2);
		send_request(MODE_DEL_HEAD, 32'sd0, 7'd0);
		send_request(MODE_DEL_TAIL, 32'sd0, 7'd0);
		send_request(MODE_SHOW, 32'sd0, 7'd0);
		send_request(MODE_DEL_TAIL, 32'sd0, 7'd0);
		send_request(MODE_SHOW, 32'sd0, 7'd0);

		foreach (plan[p]) begin
			quiet_tx = (p == 3);
			repeat (PHASE_ITEMS)
				send_request(pick_mode(plan[p]), pick_value(), pick_position());
		end
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		// anything extra would show up here
		repeat (2 * DEPTH + 8) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$error("%0d results never arrived", sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
